// ===== hw/rtl/etfp_pkg.sv =====
// Shared constants and register codes for the escape-time fractal pixel block.
package etfp_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int FRACTION_BITS = 28;

   localparam int ITER_WIDTH  = 16;
   localparam int GRAY_WIDTH  = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;

   localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = 16'd256;

   // Register indexes (byte address = 4 * index).
   typedef enum logic [1:0] {
      REG_FRACTAL_MODE = 2'd0,
      REG_MAX_ITER     = 2'd1,
      REG_JULIA_C_RE   = 2'd2,
      REG_JULIA_C_IM   = 2'd3
   } csr_index_type;

   // Gray scale: floor(n * 255 / 40) for n below 40, by reciprocal 13108 / 2^19.
   localparam int GRAY_SAT_COUNT = 40;
   localparam int GRAY_MUL       = 255 * 13108;
   localparam int GRAY_SHIFT     = 19;
   localparam int GRAY_PROD_W    = 29;

endpackage

// ===== hw/rtl/etfp_req_if.sv =====
// Handshake channels: point requests in, pixel classification out.
interface etfp_req_if #(
   parameter int CW = etfp_pkg::COORD_WIDTH
);
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] point_re;
   logic signed [CW-1:0] point_im;

   modport source (output valid, output point_re, output point_im, input ready);
   modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

interface etfp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                inside_res;
   logic [etfp_pkg::ITER_WIDTH-1:0]     escape_count;
   logic [etfp_pkg::GRAY_WIDTH-1:0]     gray_level;

   modport source (output valid, output inside_res, output escape_count,
                   output gray_level, input ready);
   modport sink   (input valid, input inside_res, input escape_count,
                   input gray_level, output ready);
endinterface

// ===== hw/rtl/etfp_root_cell.sv =====
// One cell of the square root chain: resolves one root bit from two radicand bits.
module etfp_root_cell #(
   parameter int CW = etfp_pkg::COORD_WIDTH
) (
   input  logic              clock,
   input  logic [CW+1:0]     rem_in,
   input  logic [CW-1:0]     root_in,
   input  logic [2*CW-1:0]   rad_in,
   output logic [CW+1:0]     rem_out,
   output logic [CW-1:0]     root_out,
   output logic [2*CW-1:0]   rad_out
);
   localparam int PW = 2 * CW;

   logic [CW+3:0] rem_sh;
   logic [CW+3:0] trial;
   logic [CW+3:0] diff;
   logic          take;

   logic [CW+1:0]   rem_ff, rem_in_nx;
   logic [CW-1:0]   root_ff, root_in_nx;
   logic [PW-1:0]   rad_ff;

   always_comb begin
      rem_sh = {rem_in, rad_in[PW-1:PW-2]};
      trial  = (CW+4)'({root_in, 2'b01});
      diff   = rem_sh - trial;
      take   = (rem_sh >= trial);
      rem_in_nx  = take ? diff[CW+1:0] : rem_sh[CW+1:0];
      root_in_nx = {root_in[CW-2:0], take};
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in_nx;
      root_ff <= root_in_nx;
      rad_ff  <= {rad_in[PW-3:0], 2'b00};
   end

   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign rad_out  = rad_ff;
endmodule

// ===== hw/rtl/etfp_root_chain.sv =====
// Row of square root cells, one registered cell per root bit.
module etfp_root_chain #(
   parameter int CW = etfp_pkg::COORD_WIDTH
) (
   input  logic              clock,
   input  logic [2*CW-1:0]   radicand,
   output logic [CW-1:0]     root
);
   localparam int PW = 2 * CW;

   logic [CW+1:0] rem_w  [CW+1];
   logic [CW-1:0] root_w [CW+1];
   logic [PW-1:0] rad_w  [CW+1];

   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign rad_w[0]  = radicand;

   for (genvar k = 0; k < CW; k++) begin : g_cell
      etfp_root_cell #(.CW(CW)) u_cell (
         .clock    (clock),
         .rem_in   (rem_w[k]),
         .root_in  (root_w[k]),
         .rad_in   (rad_w[k]),
         .rem_out  (rem_w[k+1]),
         .root_out (root_w[k+1]),
         .rad_out  (rad_w[k+1])
      );
   end

   assign root = root_w[CW];
endmodule

// ===== hw/rtl/escape_time_fractal_pixel.sv =====
// Escape-time fractal pixel classifier (Mandelbrot / Julia), top level.
//
// Usage: one complex point per transfer on req_chan (point_re, point_im, signed
// fixed point with FRACTION_BITS fraction bits). One result per point on
// rsp_chan: inside_res, escape_count and gray_level.
// Registers on the csr_ APB port: fractal_mode (0x0), max_iterations (0x4),
// julia_c_re (0x8), julia_c_im (0xC); write only while the block is idle.
// A point ends when a part of z passes 2, when |z|^2 > 4 (that test looks at
// z one pass late) or when the iteration limit runs out; with a zero limit
// the point goes straight to the result.
// Mandelbrot point with both parts within 2: a cardioid test comes first
// (square root in the cell chain, one bit per cell); a point found in the
// cardioid goes straight to the result without iterating.
// Each iteration goes through the one shared complex multiply / add unit
// (products registered, then update and escape test).
// One point is worked on at a time; req_chan is ready only when idle, so the
// next transfer can come at the earliest once rsp valid has risen.
// The result sits in an output register; a stalled receiver only delays the
// next finish, the next point can still be taken while it waits.
// Reset: synchronous, active high; clears control and restores register
// defaults (Mandelbrot, 256 iterations, Julia c = 0 + 0.5i).
module escape_time_fractal_pixel #(
   parameter int COORD_WIDTH   = etfp_pkg::COORD_WIDTH,
   parameter int FRACTION_BITS = etfp_pkg::FRACTION_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   etfp_req_if.sink                             req_chan,
   etfp_rsp_if.source                           rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [etfp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [etfp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [etfp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   localparam int CW  = COORD_WIDTH;
   localparam int FB  = FRACTION_BITS;
   localparam int PW  = 2 * CW;
   localparam int NW  = PW + 2;
   localparam int IW  = etfp_pkg::ITER_WIDTH;
   localparam int GW  = etfp_pkg::GRAY_WIDTH;
   localparam int DW  = etfp_pkg::CSR_DATA_W;
   localparam int CNW = $clog2(CW);

   localparam logic signed [NW-1:0] LIM     = NW'(1) <<< (FB + 1);
   localparam logic signed [NW-1:0] FOUR    = NW'(1) <<< (2 * FB + 2);
   localparam logic signed [NW-1:0] QUART2  = NW'(1) <<< (2 * FB - 2);
   localparam logic signed [CW-1:0] QUARTER = CW'(1) <<< (FB - 2);
   localparam logic signed [CW-1:0] HALF    = CW'(1) <<< (FB - 1);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CSQ   = 9'b000000010,
      S_ROOT  = 9'b000000100,
      S_PLOAD = 9'b000001000,
      S_PSQ   = 9'b000010000,
      S_CCMP  = 9'b000100000,
      S_MUL   = 9'b001000000,
      S_ADD   = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   // ---------------- configuration registers ----------------
   logic                 mode_ff;
   logic [IW-1:0]        max_iter_ff;
   logic signed [CW-1:0] jc_re_ff;
   logic signed [CW-1:0] jc_im_ff;
   logic                 csr_wr;
   etfp_pkg::csr_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = etfp_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         max_iter_ff <= etfp_pkg::MAX_ITER_RESET;
         jc_re_ff    <= '0;
         jc_im_ff    <= HALF;
      end else if (csr_wr) begin
         unique case (csr_idx)
            etfp_pkg::REG_FRACTAL_MODE: mode_ff     <= csr_pwdata[0];
            etfp_pkg::REG_MAX_ITER:     max_iter_ff <= csr_pwdata[IW-1:0];
            etfp_pkg::REG_JULIA_C_RE:   jc_re_ff    <= CW'(signed'(csr_pwdata));
            etfp_pkg::REG_JULIA_C_IM:   jc_im_ff    <= CW'(signed'(csr_pwdata));
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         etfp_pkg::REG_FRACTAL_MODE: csr_prdata = DW'(mode_ff);
         etfp_pkg::REG_MAX_ITER:     csr_prdata = DW'(max_iter_ff);
         etfp_pkg::REG_JULIA_C_RE:   csr_prdata = DW'(jc_re_ff);
         etfp_pkg::REG_JULIA_C_IM:   csr_prdata = DW'(jc_im_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // ---------------- datapath registers ----------------
   state_type            state_ff, state_in;
   logic signed [CW-1:0] zr_ff, zi_ff, cr_ff, ci_ff, pr_ff, pi_ff;
   logic signed [PW-1:0] m0_ff, m1_ff, m2_ff;
   logic [CW-1:0]        p_ff;
   logic [IW:0]          iter_ff;
   logic [IW-1:0]        limit_ff;
   logic                 check_ff;
   logic [CNW-1:0]       cnt_ff;
   logic                 fin_inside_ff;
   logic [IW-1:0]        fin_count_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_inside_ff;
   logic [IW-1:0]        rsp_count_ff;
   logic [GW-1:0]        rsp_gray_ff;

   // shared multiply unit: products of the z registers, registered every cycle
   always_ff @(posedge clock) begin
      m0_ff <= PW'(zr_ff) * PW'(zr_ff);
      m1_ff <= PW'(zi_ff) * PW'(zi_ff);
      m2_ff <= PW'(zr_ff) * PW'(zi_ff);
   end

   // cardioid square root
   logic [PW-1:0] radicand;
   logic [CW-1:0] root_w;
   assign radicand = PW'(m0_ff + m1_ff);

   etfp_root_chain #(.CW(CW)) u_root (
      .clock    (clock),
      .radicand (radicand),
      .root     (root_w)
   );

   // update and escape test
   logic signed [NW-1:0] nr, ni, sq_sum, lhs, rhs, xw, yw;
   logic                 nbig, sq_out, pbig, card_in, accept;

   always_comb begin
      nr     = ((NW'(m0_ff) - NW'(m1_ff)) >>> FB) + NW'(cr_ff);
      ni     = (NW'(m2_ff) >>> (FB - 1)) + NW'(ci_ff);
      nbig   = (nr > LIM) || (nr < -LIM) || (ni > LIM) || (ni < -LIM);
      sq_sum = NW'(m0_ff) + NW'(m1_ff);
      sq_out = check_ff && (sq_sum > FOUR);
      lhs    = NW'(pr_ff) <<< FB;
      rhs    = (NW'($signed({1'b0, p_ff})) <<< FB) - (NW'(m0_ff) <<< 1) + QUART2;
      card_in = lhs < rhs;
      xw     = NW'(req_chan.point_re);
      yw     = NW'(req_chan.point_im);
      pbig   = (xw > LIM) || (xw < -LIM) || (yw > LIM) || (yw < -LIM);
      accept = req_chan.valid && req_chan.ready;
   end

   assign req_chan.ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (max_iter_ff == '0)
                  state_in = S_DONE;
               else if (!mode_ff && !pbig)
                  state_in = S_CSQ;
               else
                  state_in = S_MUL;
            end
         end
         S_CSQ:   state_in = S_ROOT;
         S_ROOT:  if (cnt_ff == CNW'(CW - 1)) state_in = S_PLOAD;
         S_PLOAD: state_in = S_PSQ;
         S_PSQ:   state_in = S_CCMP;
         S_CCMP:  state_in = card_in ? S_DONE : S_MUL;
         S_MUL:   state_in = S_ADD;
         S_ADD: begin
            if (sq_out || (iter_ff == {1'b0, limit_ff}) || nbig)
               state_in = S_DONE;
            else
               state_in = S_MUL;
         end
         S_DONE:  if (!rsp_valid_ff || rsp_chan.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff <= (state_ff == S_ROOT) ? cnt_ff + CNW'(1) : '0;
      case (state_ff)
         S_IDLE: begin
            pr_ff         <= req_chan.point_re;
            pi_ff         <= req_chan.point_im;
            limit_ff      <= max_iter_ff;
            iter_ff       <= '0;
            check_ff      <= 1'b0;
            fin_inside_ff <= 1'b1;
            fin_count_ff  <= '0;
            if (mode_ff) begin
               zr_ff <= req_chan.point_re;
               zi_ff <= req_chan.point_im;
               cr_ff <= jc_re_ff;
               ci_ff <= jc_im_ff;
            end else if (!pbig) begin
               zr_ff <= req_chan.point_re - QUARTER;
               zi_ff <= req_chan.point_im;
            end else begin
               zr_ff <= '0;
               zi_ff <= '0;
               cr_ff <= req_chan.point_re;
               ci_ff <= req_chan.point_im;
            end
         end
         S_PLOAD: begin
            p_ff  <= root_w;
            zr_ff <= signed'(root_w);
         end
         S_CCMP: begin
            zr_ff <= '0;
            zi_ff <= '0;
            cr_ff <= pr_ff;
            ci_ff <= pi_ff;
         end
         S_ADD: begin
            if (sq_out) begin
               fin_inside_ff <= 1'b0;
               fin_count_ff  <= IW'(iter_ff - 1'b1);
            end else if (iter_ff != {1'b0, limit_ff}) begin
               if (nbig) begin
                  fin_inside_ff <= 1'b0;
                  fin_count_ff  <= iter_ff[IW-1:0];
               end
               zr_ff    <= nr[CW-1:0];
               zi_ff    <= ni[CW-1:0];
               iter_ff  <= iter_ff + 1'b1;
               check_ff <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   // output register and gray scale
   logic [etfp_pkg::GRAY_PROD_W-1:0] gray_prod;
   logic [GW-1:0]                    gray_w;
   logic                             load_out;

   always_comb begin
      gray_prod = etfp_pkg::GRAY_PROD_W'(fin_count_ff[5:0]) *
                  etfp_pkg::GRAY_PROD_W'(etfp_pkg::GRAY_MUL);
      if (fin_inside_ff)
         gray_w = '0;
      else if (fin_count_ff >= IW'(etfp_pkg::GRAY_SAT_COUNT))
         gray_w = '1;
      else
         gray_w = GW'(gray_prod >> etfp_pkg::GRAY_SHIFT);
      load_out = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_inside_ff <= fin_inside_ff;
         rsp_count_ff  <= fin_count_ff;
         rsp_gray_ff   <= gray_w;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.inside_res   = rsp_inside_ff;
   assign rsp_chan.escape_count = rsp_count_ff;
   assign rsp_chan.gray_level   = rsp_gray_ff;
endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the escape-time fractal pixel classifier.
`timescale 1ns / 100ps

module tb;

   localparam int  CW         = etfp_pkg::COORD_WIDTH;
   localparam int  FB         = etfp_pkg::FRACTION_BITS;
   localparam int  IW         = etfp_pkg::ITER_WIDTH;
   localparam int  GW         = etfp_pkg::GRAY_WIDTH;
   localparam int  AW         = etfp_pkg::CSR_ADDR_W;
   localparam int  DW         = etfp_pkg::CSR_DATA_W;
   localparam int  NUM_PHASES = 10;
   localparam int  LONG_HOLD  = 400;
   localparam int  CYCLE_CAP  = 3000000;
   localparam int  PHASE_HOLD = 7;

   typedef struct packed {
      logic signed [CW-1:0] re;
      logic signed [CW-1:0] im;
   } point_type;

   typedef struct packed {
      logic          in_set;
      logic [IW-1:0] count;
      logic [GW-1:0] gray;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   etfp_req_if req ();
   etfp_rsp_if rsp ();

   logic          csr_psel, csr_penable, csr_pwrite;
   logic [AW-1:0] csr_paddr;
   logic [DW-1:0] csr_pwdata, csr_prdata;
   logic          csr_pready;

   escape_time_fractal_pixel DUT (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req),
      .rsp_chan   (rsp),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   // Shadow copy of the block's registers, used by the classifier model.
   logic                 shadow_mode;
   logic [IW-1:0]        shadow_iter;
   logic signed [CW-1:0] shadow_c_re, shadow_c_im;

   point_type point_queue[$];   // points waiting to be offered
   pixel_type pixel_queue[$];   // classifications still owed by the block
   int     mismatches  = 0;
   int     phase_num   = 0;
   bit     no_idle     = 1'b0;
   int     cycle_count = 0;

   // ---------------------------------------------------------------------
   // Classifier model
   // ---------------------------------------------------------------------
   function automatic longint unsigned isqrt64(longint unsigned q);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > q) b = b >> 2;
      while (b != 0) begin
         if (q >= r + b) begin
            q = q - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Main cardioid test; anything with a part beyond 2 is outside.
   function automatic bit in_main_cardioid(longint x, longint y);
      longint lim, a, p, lhs, rhs;
      longint unsigned q;
      lim = 64'sd1 <<< (FB + 1);
      if (x > lim || -x > lim || y > lim || -y > lim) return 1'b0;
      a   = x - (64'sd1 <<< (FB - 2));
      q   = a * a + y * y;
      p   = longint'(isqrt64(q));
      lhs = x <<< FB;
      rhs = (p <<< FB) - 2 * p * p + (64'sd1 <<< (2 * FB - 2));
      return lhs < rhs;
   endfunction

   function automatic pixel_type classify_point(point_type pt);
      longint    lim, four, zr, zi, cr, ci, nr, ni;
      int        n, gray;
      bit        escaped;
      pixel_type res;
      lim     = 64'sd1 <<< (FB + 1);
      four    = 64'sd1 <<< (2 * FB + 2);
      escaped = 1'b0;
      res     = '0;
      if (shadow_mode) begin
         zr = pt.re;  zi = pt.im;  cr = shadow_c_re;  ci = shadow_c_im;
      end else begin
         zr = 0;  zi = 0;  cr = pt.re;  ci = pt.im;
      end
      if (shadow_mode || !in_main_cardioid(pt.re, pt.im)) begin
         for (n = 0; n < int'(shadow_iter); n++) begin
            // >>> on a signed value floors toward minus infinity
            nr = ((zr * zr - zi * zi) >>> FB) + cr;
            ni = ((zr * zi) >>> (FB - 1)) + ci;
            zr = nr;
            zi = ni;
            if (zr > lim || -zr > lim || zi > lim || -zi > lim ||
                zr * zr + zi * zi > four) begin
               escaped = 1'b1;
               break;
            end
         end
      end
      if (escaped) begin
         gray      = (n * 255) / etfp_pkg::GRAY_SAT_COUNT;
         res.count = n[IW-1:0];
         res.gray  = (gray > 255) ? 8'd255 : gray[7:0];
      end else begin
         res.in_set = 1'b1;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: offers queued points, random gap after each transfer
   // ---------------------------------------------------------------------
   int        req_gap;
   point_type req_next;

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req.valid && req.ready)
            pixel_queue.push_back(classify_point('{re: req.point_re, im: req.point_im}));
         if (!req.valid || req.ready) begin
            if (req_gap == 0 && point_queue.size() > 0) begin
               req_next     = point_queue.pop_front();
               req.valid    <= 1'b1;
               req.point_re <= req_next.re;
               req.point_im <= req_next.im;
               req_gap      <= no_idle ? 0 : $urandom_range(0, 7);
            end else begin
               req.valid <= 1'b0;
               if (req_gap > 0) req_gap <= req_gap - 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: random stall after each transfer, compare with model
   // ---------------------------------------------------------------------
   logic      rsp_ready_draw;
   int        rsp_stall;
   int        stall_draw;
   int        hold_left = 0;
   bit        hold_done = 1'b0;
   pixel_type got, want;

   // Long receiver hold-off, once, so the block backs up into its input.
   always @(posedge clock) begin
      if (hold_left > 0)
         hold_left <= hold_left - 1;
      else if (!hold_done && phase_num == PHASE_HOLD) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end
   end

   assign rsp.ready = rsp_ready_draw && (hold_left == 0);

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready_draw <= 1'b0;
         rsp_stall      <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = '{in_set: rsp.inside_res, count: rsp.escape_count,
                    gray: rsp.gray_level};
            if (pixel_queue.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result transfer: %p", got);
               mismatches++;
            end else begin
               want = pixel_queue.pop_front();
               if (got.in_set !== want.in_set || got.count !== want.count ||
                   got.gray !== want.gray) begin
                  if (mismatches < 10)
                     $display("pixel mismatch: exp %0d/%0d/%0d, got %0d/%0d/%0d",
                              want.in_set, want.count, want.gray,
                              got.in_set, got.count, got.gray);
                  mismatches++;
               end
            end
            stall_draw = no_idle ? 0 : $urandom_range(0, 7);
            rsp_stall      <= stall_draw;
            rsp_ready_draw <= (stall_draw == 0);
         end else if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready_draw <= (rsp_stall == 1);
         end else begin
            rsp_ready_draw <= 1'b1;
         end
      end
   end

   // Run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // CSR access: write, then read back and check the register width
   // ---------------------------------------------------------------------
   task automatic csr_write(etfp_pkg::csr_index_type idx, logic [DW-1:0] value);
      logic [DW-1:0] mask, kept;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= AW'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         etfp_pkg::REG_FRACTAL_MODE: begin
            shadow_mode = value[0];
            mask = 32'h1;
         end
         etfp_pkg::REG_MAX_ITER: begin
            shadow_iter = value[IW-1:0];
            mask = 32'hFFFF;
         end
         etfp_pkg::REG_JULIA_C_RE: begin
            shadow_c_re = value;
            mask = '1;
         end
         default: begin
            shadow_c_im = value;
            mask = '1;
         end
      endcase
      // read back: setup then access
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      kept = csr_prdata & mask;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (kept !== (value & mask)) begin
         if (mismatches < 10)
            $display("register %s readback: expected %h, got %h",
                     idx.name(), value & mask, kept);
         mismatches++;
      end
   endtask

   task automatic wait_drained();
      while (point_queue.size() > 0 || req.valid || pixel_queue.size() > 0)
         @(posedge clock);
   endtask

   // Mostly points in the square with both parts within 2.5, some over the whole range.
   function automatic point_type draw_point();
      point_type pt;
      if ($urandom_range(0, 7) == 0) begin
         pt.re = $urandom;
         pt.im = $urandom;
      end else begin
         pt.re = $signed($urandom_range(0, 32'h5000_0000)) - 32'sh2800_0000;
         pt.im = $signed($urandom_range(0, 32'h5000_0000)) - 32'sh2800_0000;
      end
      return pt;
   endfunction

   function automatic logic signed [CW-1:0] fx(real v);
      return $rtoi(v * 268435456.0);
   endfunction

   task automatic push_point(logic signed [CW-1:0] re, logic signed [CW-1:0] im);
      point_queue.push_back('{re: re, im: im});
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   int                   ph_mode  [NUM_PHASES];
   int                   ph_iter  [NUM_PHASES];
   logic signed [CW-1:0] ph_cre   [NUM_PHASES];
   logic signed [CW-1:0] ph_cim   [NUM_PHASES];
   int                   ph_items [NUM_PHASES];

   initial begin
      int p, k;
      req.valid    = 1'b0;
      req.point_re = '0;
      req.point_im = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      shadow_mode  = 1'b0;
      shadow_iter  = etfp_pkg::MAX_ITER_RESET;
      shadow_c_re  = '0;
      shadow_c_im  = 32'sd134217728;

      // phase 0 runs at reset defaults; the rest rewrite every register
      ph_mode = '{0, 0, 1, 0, 1, 0, 1, 1, 0, 1};
      ph_iter = '{256, 0, 0, 40, 50, 1, 30, 64, 100, 65535};
      ph_cre  = '{0, 0, $urandom, 0, fx(-0.8), 0, 32'sh7FFF_FFFF, $urandom, 0, 0};
      ph_cim  = '{0, 0, $urandom, 0, fx(0.156), 0, 32'sh8000_0000, $urandom, 0, 0};
      ph_items = '{0, 10, 6, 300, 300, 100, 100, 300, 150, 0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         no_idle = (p % 3 == 2);
         if (p > 0) begin
            // mode written with stray upper bits: only bit 0 may stick
            csr_write(etfp_pkg::REG_FRACTAL_MODE, {31'h7FFF_FFFF, 1'(ph_mode[p])});
            csr_write(etfp_pkg::REG_MAX_ITER, ph_iter[p]);
            csr_write(etfp_pkg::REG_JULIA_C_RE, ph_cre[p]);
            csr_write(etfp_pkg::REG_JULIA_C_IM, ph_cim[p]);
         end
         phase_num = p;
         if (p == 0) begin
            // directed: extremes, cardioid interior / cusp / edge, real axis
            push_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
            push_point(32'sh8000_0000, 32'sh8000_0000);
            push_point(32'sh7FFF_FFFF, 32'sh8000_0000);
            push_point(32'sh8000_0000, 32'sh7FFF_FFFF);
            push_point(0, 0);
            push_point(fx(-0.5), 0);
            push_point(fx(0.25), 0);
            push_point(fx(0.2499), fx(0.0001));
            push_point(fx(-0.75), fx(0.05));
            push_point(fx(-2.0), 0);
            push_point(fx(2.0), 0);
            push_point(fx(2.0) + 1, 0);
            push_point(0, fx(-2.0) - 1);
            push_point(fx(0.3), fx(0.5));
            push_point(fx(-1.0), 0);
            push_point(fx(0.4), fx(0.3));
            push_point(fx(-0.1), fx(0.9));
            push_point(fx(0.28), fx(0.01));
            push_point(32'sh0000_0001, 32'shFFFF_FFFF);
            push_point(fx(-1.76), fx(0.02));
         end else if (p == NUM_PHASES - 1) begin
            // largest limit (Julia, c = 0): two points that never escape, two fast ones
            push_point(0, 0);
            push_point(fx(1.5), fx(1.5));
            push_point(fx(-0.5), fx(0.7));
            push_point(32'sh8000_0000, 0);
         end else begin
            for (k = 0; k < ph_items[p]; k++)
               point_queue.push_back(draw_point());
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pixel_queue.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/etfp_pkg.sv
hw/rtl/etfp_req_if.sv
hw/rtl/etfp_root_cell.sv
hw/rtl/etfp_root_chain.sv
hw/rtl/escape_time_fractal_pixel.sv
test/tb.sv
